>>> sv/kst_pkg.sv
// Shared types and codes for the key slot table.
`default_nettype none

package kst_pkg;

  localparam int KEY_W  = 64;
  localparam int DMAX_W = 64;

  localparam logic [1:0] KIND_STORE    = 2'd0;
  localparam logic [1:0] KIND_RETRIEVE = 2'd1;
  localparam logic [1:0] KIND_EXISTS   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic              vld;
    logic              hit_seen;
    logic              free_seen;
    logic [DMAX_W-1:0] data;
  } kst_tok_t;

  typedef struct packed {
    logic en;
    logic new_id;
  } kst_wr_t;

endpackage

`default_nettype wire

>>> sv/kst_cell.sv
// One slot of the key slot table with its stage of the search token chain.
`default_nettype none

module kst_cell import kst_pkg::*; #(
  parameter int DATA_W = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire kst_tok_t          tok_i,
  output kst_tok_t               tok_o,
  input  wire logic [KEY_W-1:0]  cmd_id,
  input  wire logic [DATA_W-1:0] cmd_data,
  input  wire logic [DATA_W-1:0] wr_mask,
  input  wire kst_wr_t           wr
);

  logic [KEY_W-1:0]  id_r, id_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic              first_hit_r, first_free_r;
  kst_tok_t          tok_r, tok_nxt;
  logic              hit, free, sel;

  assign hit  = (id_r == cmd_id);
  assign free = (id_r == '0);
  assign sel  = wr.en & (wr.new_id ? first_free_r : first_hit_r);

  always_comb begin
    tok_nxt.vld       = tok_i.vld;
    tok_nxt.hit_seen  = tok_i.hit_seen | hit;
    tok_nxt.free_seen = tok_i.free_seen | free;
    if (tok_i.hit_seen) begin
      tok_nxt.data = tok_i.data;
    end else if (hit) begin
      tok_nxt.data = DMAX_W'(data_r);
    end else begin
      tok_nxt.data = '0;
    end
    id_nxt   = id_r;
    data_nxt = data_r;
    if (sel) begin
      if (wr.new_id) begin
        id_nxt = cmd_id;
      end
      data_nxt = (data_r & ~wr_mask) | (cmd_data & wr_mask);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r         <= '0;
      data_r       <= '0;
      first_hit_r  <= 1'b0;
      first_free_r <= 1'b0;
      tok_r        <= '0;
    end else begin
      id_r   <= id_nxt;
      data_r <= data_nxt;
      tok_r  <= tok_nxt;
      if (tok_i.vld) begin
        first_hit_r  <= hit & ~tok_i.hit_seen;
        first_free_r <= free & ~tok_i.free_seen;
      end
    end
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

>>> sv/key_slot_table_unit.sv
// Top level of the key slot table: command control, slot chain and result register.
// The result register loads at commit, once the token has walked the slot chain.
// Input is stalled until the last transaction is done; the search token walks the
// slot chain one cell per cycle, then commit writes the slot when output is free.
// A waiting result does not block acceptance of the next input transaction.
// Reset (synchronous, rst_n low) frees every slot, clears all slot data and the count.
`default_nettype none

module key_slot_table_unit import kst_pkg::*; #(
  parameter int SLOTS      = 16,
  parameter int DATA_BYTES = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_kind,
  input  wire logic [KEY_W-1:0]  in_key_id,
  input  wire logic [63:0]       in_key_data,
  input  wire logic [3:0]        in_store_length,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             out_status,
  output logic                   out_exists_flag,
  output logic [DMAX_W-1:0]      out_data_out,
  output logic [4:0]             out_used_count
);

  localparam int DW = 8 * DATA_BYTES;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_START  = 2'd1;
  localparam logic [1:0] S_WALK   = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [1:0]        kind_r;
  logic [KEY_W-1:0]  id_r;
  logic [DW-1:0]     data_r;
  logic [3:0]        len_r;
  logic              any_hit_r, any_free_r;
  logic [DMAX_W-1:0] hit_data_r;
  logic [4:0]        claimed_r, claimed_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              exists_r;
  logic [DMAX_W-1:0] dout_r, dout_nxt;
  logic              accept, out_free, commit;
  logic [3:0]        len_sat;
  logic [DW-1:0]     wmask;
  kst_wr_t           wr;
  kst_tok_t          tok [SLOTS+1];

  assign accept   = in_valid & ~in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = ~out_valid_r | ~out_stall;
  assign commit   = (state_r == S_COMMIT) & out_free;

  assign len_sat = (len_r > 4'(DATA_BYTES)) ? 4'(DATA_BYTES) : len_r;

  for (genvar b = 0; b < DATA_BYTES; b++) begin : g_mask
    assign wmask[8*b +: 8] = {8{4'(b) < len_sat}};
  end

  assign wr.en     = commit & (kind_r == KIND_STORE) & (any_hit_r | any_free_r);
  assign wr.new_id = ~any_hit_r;

  assign tok[0].vld       = (state_r == S_START);
  assign tok[0].hit_seen  = 1'b0;
  assign tok[0].free_seen = 1'b0;
  assign tok[0].data      = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_slot
    kst_cell #(
      .DATA_W (DW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_i    (tok[i]),
      .tok_o    (tok[i+1]),
      .cmd_id   (id_r),
      .cmd_data (data_r),
      .wr_mask  (wmask),
      .wr       (wr)
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (tok[SLOTS].vld) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    claimed_nxt = claimed_r;
    if (wr.en && wr.new_id) begin
      claimed_nxt = claimed_r + 5'd1;
    end
    status_nxt = ST_OK;
    dout_nxt   = '0;
    unique case (kind_r)
      KIND_STORE: begin
        if (!any_hit_r && !any_free_r) begin
          status_nxt = ST_FULL;
        end
      end
      KIND_RETRIEVE: begin
        if (any_hit_r) begin
          dout_nxt = hit_data_r;
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      KIND_EXISTS: begin
        status_nxt = ST_OK;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
    out_valid_nxt = out_valid_r & out_stall;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      claimed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      claimed_r   <= claimed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      id_r   <= in_key_id;
      data_r <= in_key_data[DW-1:0];
      len_r  <= in_store_length;
    end
    if ((state_r == S_WALK) && tok[SLOTS].vld) begin
      any_hit_r  <= tok[SLOTS].hit_seen;
      any_free_r <= tok[SLOTS].free_seen;
      hit_data_r <= tok[SLOTS].data;
    end
    if (commit) begin
      status_r <= status_nxt;
      exists_r <= any_hit_r;
      dout_r   <= dout_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_exists_flag = exists_r;
  assign out_data_out    = dout_r;
  assign out_used_count  = claimed_r;

  a_tok_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    tok[SLOTS].vld |-> (state_r == S_WALK))
    else $error("search token left the chain outside the walk phase");

  a_claim_count: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.en && wr.new_id) |=> (claimed_r == 5'($past(claimed_r) + 5'd1)))
    else $error("slot claim did not advance the used count");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT && !out_free) |=> (state_r == S_COMMIT && out_valid_r))
    else $error("commit left while the result register was occupied");

  a_count_only_on_store: assert property (@(posedge clk) disable iff (!rst_n)
    (claimed_r != claimed_nxt) |-> (commit && kind_r == KIND_STORE && !any_hit_r))
    else $error("used count changed outside a store that claims a slot");

endmodule

`default_nettype wire
